### design/tpfd_pkg.sv
// ----------------------------------------------------------------------------
// Texture pixel format decoder package
// Shared widths, format codes, register indexes and the decoded-pixel type.
// ----------------------------------------------------------------------------
package tpfd_pkg;

	// Image size limits and field widths.
	localparam int MAX_DIM  = 4096;
	localparam int DIM_W    = 13;
	localparam int COORD_W  = 12;
	localparam int MODE_W   = 3;
	localparam int REG_IDX_W = 2;
	localparam int WORD_W   = 64;
	localparam int RGBA_W   = 32;

	// Format mode codes.
	localparam logic [MODE_W-1:0] MODE_RGBA16    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_R11G11B10 = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RGBA8     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BGRA8     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_BC1       = 3'd4;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_FORMAT_MODE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// Color and status of one decoded pixel.
	typedef struct packed {
		logic [RGBA_W-1:0] rgba;
		logic              err;
	} pix_color_t;

endpackage

### design/tpfd_word_if.sv
// ----------------------------------------------------------------------------
// Source word channel
// Valid/ready channel that carries one source word per beat.
// ----------------------------------------------------------------------------
interface tpfd_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] source_word;

	modport source (output valid, output source_word, input ready);
	modport sink (input valid, input source_word, output ready);
endinterface

### design/tpfd_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one RGBA8 pixel with coordinates per beat.
// ----------------------------------------------------------------------------
interface tpfd_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_rgba;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic        last_of_run;
	logic        format_error;

	modport source (output valid, output pixel_rgba, output pixel_x, output pixel_y,
		output last_of_run, output format_error, input ready);
	modport sink (input valid, input pixel_rgba, input pixel_x, input pixel_y,
		input last_of_run, input format_error, output ready);
endinterface

### design/tpfd_color_decode.sv
// ----------------------------------------------------------------------------
// Pixel color decode
// Turns a held source word into the RGBA8 color of one pixel: the single
// pixel of a linear format, or pixel blk_idx of a BC1 block.
// ----------------------------------------------------------------------------
module tpfd_color_decode
	import tpfd_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	input  logic [MODE_W-1:0] mode,
	input  logic [3:0]        blk_idx,
	output pix_color_t        color
);

	logic [15:0] c0;
	logic [15:0] c1;
	logic [31:0] idx_bits;
	logic [1:0]  sel;
	logic        four_color;
	logic [7:0]  p0 [3];
	logic [7:0]  p1 [3];
	logic [7:0]  p2 [3];
	logic [7:0]  p3 [3];
	logic [9:0]  sum_a [3];
	logic [9:0]  sum_b [3];
	logic [8:0]  sum_h [3];
	logic [19:0] prod_a [3];
	logic [19:0] prod_b [3];
	logic [31:0] pal [4];

	// Endpoint colors expanded from 5:6:5.
	assign c0 = word[15:0];
	assign c1 = word[31:16];
	assign idx_bits = word[63:32];
	assign four_color = (c0 > c1);

	always_comb begin
		p0[0] = {c0[15:11], 3'b000};
		p0[1] = {c0[10:5], 2'b00};
		p0[2] = {c0[4:0], 3'b000};
		p1[0] = {c1[15:11], 3'b000};
		p1[1] = {c1[10:5], 2'b00};
		p1[2] = {c1[4:0], 3'b000};
	end

	// Interpolated entries; thirds use a multiply by 683 and a shift by 11,
	// which is exact for sums below 2048.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_a[ch]  = {1'b0, p0[ch], 1'b0} + {2'b00, p1[ch]};
			sum_b[ch]  = {2'b00, p0[ch]} + {1'b0, p1[ch], 1'b0};
			sum_h[ch]  = {1'b0, p0[ch]} + {1'b0, p1[ch]};
			prod_a[ch] = {10'd0, sum_a[ch]} * 20'd683;
			prod_b[ch] = {10'd0, sum_b[ch]} * 20'd683;
			if (four_color) begin
				p2[ch] = prod_a[ch][18:11];
				p3[ch] = prod_b[ch][18:11];
			end else begin
				p2[ch] = sum_h[ch][8:1];
				p3[ch] = 8'd0;
			end
		end
	end

	// Palette packed as RGBA8; transparent black in three-color blocks.
	always_comb begin
		pal[0] = {8'hFF, p0[2], p0[1], p0[0]};
		pal[1] = {8'hFF, p1[2], p1[1], p1[0]};
		pal[2] = {8'hFF, p2[2], p2[1], p2[0]};
		pal[3] = {(four_color ? 8'hFF : 8'h00), p3[2], p3[1], p3[0]};
	end

	assign sel = idx_bits[{blk_idx, 1'b0} +: 2];

	// Format select.
	always_comb begin
		color.err = 1'b0;
		unique case (mode)
			MODE_RGBA16: begin
				color.rgba = {word[63:56], word[47:40], word[31:24], word[15:8]};
			end
			MODE_R11G11B10: begin
				color.rgba = {8'hFF, word[9:2], word[20:13], word[31:24]};
			end
			MODE_RGBA8: begin
				color.rgba = word[31:0];
			end
			MODE_BGRA8: begin
				color.rgba = {word[31:24], word[7:0], word[15:8], word[23:16]};
			end
			MODE_BC1: begin
				color.rgba = pal[sel];
			end
			default: begin
				color.rgba = '0;
				color.err  = 1'b1;
			end
		endcase
	end

endmodule

### design/texture_pixel_format_decoder_top.sv
// ----------------------------------------------------------------------------
// Texture pixel format decoder
// Converts source words to RGBA8 pixels tagged with raster coordinates.
//
//   Port    Dir   Beat contents
//   src     sink  source_word (64 bits)
//   pix     src   pixel_rgba, pixel_x, pixel_y, last_of_run, format_error
//   wr_*    in    register write: wr_en, wr_index, wr_data (13 bits)
//
// A word passes an input register, the color decode and an output register.
// Linear formats and error results give one pixel per cycle while pix is
// ready; a BC1 block holds the input register for 16 pixels, one per cycle
// while pix is ready. arst_n clears the cursors and sets mode 0, size 4x4.
// A stalled pix channel holds the output register; src keeps accepting as
// long as the input register drains into the output register.
// ----------------------------------------------------------------------------
module texture_pixel_format_decoder_top
	import tpfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [DIM_W-1:0]     wr_data,
	tpfd_word_if.sink            src,
	tpfd_pixel_if.source         pix
);

	logic [MODE_W-1:0]  mode_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [WORD_W-1:0]  word_s1;
	logic               valid_s1;
	logic [3:0]         blk_idx_q;
	logic [COORD_W-1:0] cursor_col_q;
	logic [COORD_W-1:0] cursor_row_q;
	logic               out_valid_q;
	logic [RGBA_W-1:0]  rgba_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic               last_q;
	logic               err_q;

	pix_color_t         color;
	logic               is_bc1;
	logic               advance;
	logic               last_pix;
	logic [DIM_W-1:0]   w_c;
	logic [DIM_W-1:0]   h_c;
	logic [DIM_W-1:0]   wl;
	logic [DIM_W-1:0]   hl;
	logic [DIM_W-1:0]   lim_w;
	logic [DIM_W-1:0]   lim_h;
	logic [COORD_W-1:0] col_src;
	logic [COORD_W-1:0] row_src;
	logic [COORD_W-1:0] base_col;
	logic [COORD_W-1:0] base_row;
	logic [DIM_W-1:0]   step;
	logic [DIM_W-1:0]   next_col;
	logic [DIM_W-1:0]   next_row;
	logic [COORD_W-1:0] upd_col;
	logic [COORD_W-1:0] upd_row;
	logic [COORD_W-1:0] pix_x;
	logic [COORD_W-1:0] pix_y;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RGBA16;
			width_q  <= DIM_W'(4);
			height_q <= DIM_W'(4);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FORMAT_MODE:  mode_q   <= wr_data[MODE_W-1:0];
				REG_IMAGE_WIDTH:  width_q  <= wr_data;
				REG_IMAGE_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	tpfd_color_decode u_decode (
		.word    (word_s1),
		.mode    (mode_q),
		.blk_idx (blk_idx_q),
		.color   (color)
	);

	// Clamped sizes; BC1 uses at least four and whole blocks.
	always_comb begin
		if (width_q == '0)                      w_c = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_DIM))     w_c = DIM_W'(MAX_DIM);
		else                                    w_c = width_q;
		if (height_q == '0)                     h_c = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_DIM))    h_c = DIM_W'(MAX_DIM);
		else                                    h_c = height_q;
		wl = (w_c < DIM_W'(4)) ? DIM_W'(4) : {w_c[DIM_W-1:2], 2'b00};
		hl = (h_c < DIM_W'(4)) ? DIM_W'(4) : {h_c[DIM_W-1:2], 2'b00};
	end

	assign is_bc1 = (mode_q == MODE_BC1);

	// Cursor normalization and advance.
	always_comb begin
		lim_w   = is_bc1 ? wl : w_c;
		lim_h   = is_bc1 ? hl : h_c;
		step    = is_bc1 ? DIM_W'(4) : DIM_W'(1);
		col_src = is_bc1 ? {cursor_col_q[COORD_W-1:2], 2'b00} : cursor_col_q;
		row_src = is_bc1 ? {cursor_row_q[COORD_W-1:2], 2'b00} : cursor_row_q;
		base_col = ({1'b0, col_src} >= lim_w) ? '0 : col_src;
		base_row = ({1'b0, row_src} >= lim_h) ? '0 : row_src;
		next_col = {1'b0, base_col} + step;
		next_row = {1'b0, base_row} + step;
		if (next_col >= lim_w) begin
			upd_col = '0;
			upd_row = (next_row >= lim_h) ? '0 : next_row[COORD_W-1:0];
		end else begin
			upd_col = next_col[COORD_W-1:0];
			upd_row = base_row;
		end
	end

	// Pixel coordinates; error results carry zero.
	always_comb begin
		if (color.err) begin
			pix_x = '0;
			pix_y = '0;
		end else if (is_bc1) begin
			pix_x = base_col + COORD_W'(blk_idx_q[1:0]);
			pix_y = base_row + COORD_W'(blk_idx_q[3:2]);
		end else begin
			pix_x = base_col;
			pix_y = base_row;
		end
	end

	assign last_pix = !is_bc1 || (blk_idx_q == 4'd15);
	assign advance  = valid_s1 && (!out_valid_q || pix.ready);
	assign src.ready = !valid_s1 || (advance && last_pix);

	// Input register and block pixel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			blk_idx_q <= '0;
		end else begin
			if (advance) begin
				blk_idx_q <= last_pix ? 4'd0 : blk_idx_q + 4'd1;
			end
			if (src.ready) begin
				valid_s1 <= src.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			word_s1 <= src.source_word;
		end
	end

	// Cursors move once per finished item, never on an error result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (advance && last_pix && !color.err) begin
			cursor_col_q <= upd_col;
			cursor_row_q <= upd_row;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rgba_q <= color.rgba;
			x_q    <= pix_x;
			y_q    <= pix_y;
			last_q <= last_pix;
			err_q  <= color.err;
		end
	end

	assign pix.valid        = out_valid_q;
	assign pix.pixel_rgba   = rgba_q;
	assign pix.pixel_x      = x_q;
	assign pix.pixel_y      = y_q;
	assign pix.last_of_run  = last_q;
	assign pix.format_error = err_q;

endmodule
